### hw/rtl/sps_pkg.sv
// Shared constants and types for the four-axis step pulse generator.
package sps_pkg;

    localparam int AXIS_COUNT          = 4;
    localparam int STEP_WIDTH          = 16;
    localparam int PERIOD_WIDTH        = 16;
    localparam int CMD_WIDTH           = 2;
    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam int APB_ADDR_WIDTH      = 3;
    localparam int APB_DATA_WIDTH      = 32;

    localparam logic [CMD_WIDTH-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_LOAD = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_STOP = 2'd2;

    // word index of the direction invert register
    localparam logic REG_DIR_INVERT = 1'b0;

    typedef struct packed {
        logic                  tick;
        logic                  load;
        logic                  clear;
        logic [STEP_WIDTH-1:0] load_steps;
    } axis_ctrl_t;

    typedef struct packed {
        logic level_now;
        logic level_next;
        logic toggled;
        logic busy_next;
    } axis_stat_t;

endpackage

### hw/rtl/sps_apb_regs.sv
// APB configuration register holding the direction invert mask.
module sps_apb_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sps_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [sps_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [sps_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    output logic [sps_pkg::AXIS_COUNT-1:0]       dir_invert_mask
);

    logic [sps_pkg::AXIS_COUNT-1:0] dir_invert_reg;
    logic                           wr_dir_invert;
    logic                           sel_dir_invert;

    assign pready         = 1'b1;
    assign sel_dir_invert = (paddr[2] == sps_pkg::REG_DIR_INVERT);
    assign wr_dir_invert  = psel && penable && pwrite && pready && sel_dir_invert;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_invert_reg <= '0;
        end else if (wr_dir_invert) begin
            dir_invert_reg <= pwdata[sps_pkg::AXIS_COUNT-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_dir_invert) begin
            prdata[sps_pkg::AXIS_COUNT-1:0] = dir_invert_reg;
        end
    end

    assign dir_invert_mask = dir_invert_reg;

endmodule

### hw/rtl/sps_axis.sv
// One axis: tick counter, period, steps left and step pin level.
module sps_axis #(
    parameter int COUNT_WIDTH = sps_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   go,
    input  sps_pkg::axis_ctrl_t    ctrl,
    input  logic [COUNT_WIDTH-1:0] load_period,
    output sps_pkg::axis_stat_t    stat
);

    logic [COUNT_WIDTH-1:0]          tick_count_reg;
    logic [COUNT_WIDTH-1:0]          tick_count_next;
    logic [COUNT_WIDTH-1:0]          period_reg;
    logic [COUNT_WIDTH-1:0]          period_next;
    logic [sps_pkg::STEP_WIDTH-1:0]  steps_left_reg;
    logic [sps_pkg::STEP_WIDTH-1:0]  steps_left_next;
    logic                            level_reg;
    logic                            level_next;
    logic [COUNT_WIDTH-1:0]          cnt_inc;
    logic                            hit;
    logic                            fire;

    assign cnt_inc = tick_count_reg + COUNT_WIDTH'(1);
    assign hit     = (period_reg != '0) && (cnt_inc >= period_reg);
    assign fire    = ctrl.tick && hit && (steps_left_reg != '0);

    always_comb begin
        tick_count_next = tick_count_reg;
        period_next     = period_reg;
        steps_left_next = steps_left_reg;
        level_next      = level_reg;
        if (ctrl.tick) begin
            tick_count_next = hit ? '0 : cnt_inc;
            if (fire) begin
                steps_left_next = steps_left_reg - sps_pkg::STEP_WIDTH'(1);
                level_next      = ~level_reg;
            end
        end
        if (ctrl.load) begin
            period_next     = load_period;
            steps_left_next = ctrl.load_steps;
        end
        if (ctrl.clear) begin
            tick_count_next = '0;
            period_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            period_reg     <= '0;
            steps_left_reg <= '0;
            level_reg      <= 1'b0;
        end else if (go) begin
            tick_count_reg <= tick_count_next;
            period_reg     <= period_next;
            steps_left_reg <= steps_left_next;
            level_reg      <= level_next;
        end
    end

    assign stat.level_now  = level_reg;
    assign stat.level_next = level_next;
    assign stat.toggled    = fire;
    assign stat.busy_next  = (steps_left_next != '0);

endmodule

### hw/rtl/four_axis_step_pulse_generator.sv
// Top level: input beat register, axis units, direction pins and result register.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_command s_steps_* s_period_* | in
//  result  | m_valid m_ready m_step_pins m_dir_pins m_toggled_mask
//          | m_busy_res m_load_rejected              | out
//  config  | psel penable pwrite paddr pwdata prdata pready | APB slave
//
// One beat per cycle while m_ready is high; each beat goes from the input register to the result register.
// The input register feeds the axis units, which update state as the beat moves to the result
// register; the result register stalls the input register only while m_ready is low.
// Synchronous reset clears all axis state, the direction level register, the invert mask and both valid flags.
module four_axis_step_pulse_generator #(
    parameter int COUNT_WIDTH = sps_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [sps_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [sps_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [sps_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                   pready,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [sps_pkg::CMD_WIDTH-1:0]          s_command,
    input  logic signed [sps_pkg::STEP_WIDTH-1:0]  s_steps_x,
    input  logic signed [sps_pkg::STEP_WIDTH-1:0]  s_steps_y,
    input  logic signed [sps_pkg::STEP_WIDTH-1:0]  s_steps_z,
    input  logic signed [sps_pkg::STEP_WIDTH-1:0]  s_steps_e,
    input  logic [sps_pkg::PERIOD_WIDTH-1:0]       s_period_x,
    input  logic [sps_pkg::PERIOD_WIDTH-1:0]       s_period_y,
    input  logic [sps_pkg::PERIOD_WIDTH-1:0]       s_period_z,
    input  logic [sps_pkg::PERIOD_WIDTH-1:0]       s_period_e,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [sps_pkg::AXIS_COUNT-1:0]         m_step_pins,
    output logic [sps_pkg::AXIS_COUNT-1:0]         m_dir_pins,
    output logic [sps_pkg::AXIS_COUNT-1:0]         m_toggled_mask,
    output logic                                   m_busy_res,
    output logic                                   m_load_rejected
);

    localparam int N = sps_pkg::AXIS_COUNT;

    logic [N-1:0]                     dir_invert_mask;
    logic [sps_pkg::STEP_WIDTH-1:0]   s_steps_arr [N];
    logic [sps_pkg::PERIOD_WIDTH-1:0] s_period_arr [N];

    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic [sps_pkg::CMD_WIDTH-1:0]    in_cmd_reg;
    logic [sps_pkg::STEP_WIDTH-1:0]   in_steps_reg [N];
    logic [sps_pkg::PERIOD_WIDTH-1:0] in_period_reg [N];

    logic                             advance;
    logic                             go;
    logic                             s_fire;
    logic                             is_tick;
    logic                             is_load;
    logic                             is_stop;
    logic                             load_ok;
    logic                             rejected;

    logic [sps_pkg::STEP_WIDTH-1:0]   mag [N];
    logic [COUNT_WIDTH-1:0]           per_cw [N];
    logic [N-1:0]                     bad;
    logic [N-1:0]                     raw_dir;
    logic [N-1:0]                     level_now;
    logic [N-1:0]                     level_next;
    logic [N-1:0]                     toggled;
    logic [N-1:0]                     busy_next;
    sps_pkg::axis_ctrl_t              axis_ctrl [N];
    sps_pkg::axis_stat_t              axis_stat [N];

    logic [N-1:0]                     dir_level_reg;
    logic [N-1:0]                     dir_level_next;

    logic                             m_valid_reg;
    logic                             m_valid_next;
    logic [N-1:0]                     m_step_reg;
    logic [N-1:0]                     m_dir_reg;
    logic [N-1:0]                     m_toggled_reg;
    logic                             m_busy_reg;
    logic                             m_rejected_reg;

    sps_apb_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .dir_invert_mask (dir_invert_mask)
    );

    assign s_steps_arr[0]  = s_steps_x;
    assign s_steps_arr[1]  = s_steps_y;
    assign s_steps_arr[2]  = s_steps_z;
    assign s_steps_arr[3]  = s_steps_e;
    assign s_period_arr[0] = s_period_x;
    assign s_period_arr[1] = s_period_y;
    assign s_period_arr[2] = s_period_z;
    assign s_period_arr[3] = s_period_e;

    // input beat register
    assign advance = !m_valid_reg || m_ready;
    assign go      = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (go) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg <= s_command;
            for (int i = 0; i < N; i++) begin
                in_steps_reg[i]  <= s_steps_arr[i];
                in_period_reg[i] <= s_period_arr[i];
            end
        end
    end

    // command decode and load check
    assign is_tick  = (in_cmd_reg == sps_pkg::CMD_TICK);
    assign is_load  = (in_cmd_reg == sps_pkg::CMD_LOAD);
    assign is_stop  = (in_cmd_reg == sps_pkg::CMD_STOP);
    assign rejected = is_load && (bad != '0);
    assign load_ok  = is_load && (bad == '0);

    for (genvar i = 0; i < N; i++) begin : g_axis
        assign mag[i] = in_steps_reg[i][sps_pkg::STEP_WIDTH-1]
                      ? (~in_steps_reg[i] + sps_pkg::STEP_WIDTH'(1))
                      : in_steps_reg[i];
        assign per_cw[i]  = COUNT_WIDTH'(in_period_reg[i]);
        assign bad[i]     = (mag[i] != '0) && (per_cw[i] == '0);
        assign raw_dir[i] = in_steps_reg[i][sps_pkg::STEP_WIDTH-1] || (in_steps_reg[i] == '0);

        assign axis_ctrl[i].tick       = is_tick;
        assign axis_ctrl[i].load       = load_ok;
        assign axis_ctrl[i].clear      = is_stop;
        assign axis_ctrl[i].load_steps = mag[i];

        sps_axis #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_axis (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .go          (go),
            .ctrl        (axis_ctrl[i]),
            .load_period (per_cw[i]),
            .stat        (axis_stat[i])
        );

        assign level_now[i]  = axis_stat[i].level_now;
        assign level_next[i] = axis_stat[i].level_next;
        assign toggled[i]    = axis_stat[i].toggled;
        assign busy_next[i]  = axis_stat[i].busy_next;
    end

    // direction pins
    assign dir_level_next = load_ok ? (raw_dir ^ dir_invert_mask) : dir_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_level_reg <= '0;
        end else if (go) begin
            dir_level_reg <= dir_level_next;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            m_step_reg     <= level_next;
            m_dir_reg      <= dir_level_next;
            m_toggled_reg  <= toggled;
            m_busy_reg     <= (busy_next != '0);
            m_rejected_reg <= rejected;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_step_pins     = m_step_reg;
    assign m_dir_pins      = m_dir_reg;
    assign m_toggled_mask  = m_toggled_reg;
    assign m_busy_res      = m_busy_reg;
    assign m_load_rejected = m_rejected_reg;

    a_toggle_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        go && !is_tick |=> (m_toggled_mask == '0))
        else $error("step toggle reported for a non-tick beat");

    a_reject_only_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        go && !is_load |=> !m_load_rejected)
        else $error("load rejection reported for a non-load beat");

    a_reject_keeps_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        go && rejected |=> $stable(dir_level_reg))
        else $error("rejected load changed direction pins");

    a_pins_follow_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> (m_step_pins == ($past(level_now) ^ m_toggled_mask)))
        else $error("step pins disagree with toggled mask");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the four-axis step pulse generator: directed table, random moves, scoreboard.
module tb_top;

    localparam logic [sps_pkg::CMD_WIDTH-1:0]      CMD_NOP         = 2'd3;
    localparam logic [sps_pkg::APB_ADDR_WIDTH-1:0] DIR_INVERT_ADDR =
        {sps_pkg::REG_DIR_INVERT, 2'b00};
    localparam logic [15:0] NIL         = 16'd0;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          PHASE_BEATS = 365;

    typedef struct packed {
        logic [sps_pkg::CMD_WIDTH-1:0]                             cmd;
        logic [sps_pkg::AXIS_COUNT-1:0][sps_pkg::STEP_WIDTH-1:0]   steps;
        logic [sps_pkg::AXIS_COUNT-1:0][sps_pkg::PERIOD_WIDTH-1:0] period;
    } move_t;

    typedef struct packed {
        logic [sps_pkg::AXIS_COUNT-1:0] step_pins;
        logic [sps_pkg::AXIS_COUNT-1:0] dir_pins;
        logic [sps_pkg::AXIS_COUNT-1:0] toggled;
        logic                           busy;
        logic                           rejected;
    } pins_t;

    typedef struct packed {
        move_t beat;
        logic  typed;
        pins_t want;
    } row_t;

    logic                                     aclk;
    logic                                     aresetn;
    logic                                     psel;
    logic                                     penable;
    logic                                     pwrite;
    logic [sps_pkg::APB_ADDR_WIDTH-1:0]       paddr;
    logic [sps_pkg::APB_DATA_WIDTH-1:0]       pwdata;
    logic [sps_pkg::APB_DATA_WIDTH-1:0]       prdata;
    logic                                     pready;
    logic                                     s_valid;
    logic                                     s_ready;
    logic [sps_pkg::CMD_WIDTH-1:0]            s_command;
    logic signed [sps_pkg::STEP_WIDTH-1:0]    s_steps_x;
    logic signed [sps_pkg::STEP_WIDTH-1:0]    s_steps_y;
    logic signed [sps_pkg::STEP_WIDTH-1:0]    s_steps_z;
    logic signed [sps_pkg::STEP_WIDTH-1:0]    s_steps_e;
    logic [sps_pkg::PERIOD_WIDTH-1:0]         s_period_x;
    logic [sps_pkg::PERIOD_WIDTH-1:0]         s_period_y;
    logic [sps_pkg::PERIOD_WIDTH-1:0]         s_period_z;
    logic [sps_pkg::PERIOD_WIDTH-1:0]         s_period_e;
    logic                                     m_valid;
    logic                                     m_ready;
    logic [sps_pkg::AXIS_COUNT-1:0]           m_step_pins;
    logic [sps_pkg::AXIS_COUNT-1:0]           m_dir_pins;
    logic [sps_pkg::AXIS_COUNT-1:0]           m_toggled_mask;
    logic                                     m_busy_res;
    logic                                     m_load_rejected;

    pins_t pin_results_q[$];
    int    errors;
    int    cycles;
    int    beats_sent;
    int    toggle_results;
    int    reject_results;
    int    src_burst;

    logic [15:0]                    tick_cnt[sps_pkg::AXIS_COUNT];
    logic [15:0]                    axis_per[sps_pkg::AXIS_COUNT];
    logic [15:0]                    steps_rem[sps_pkg::AXIS_COUNT];
    logic [sps_pkg::AXIS_COUNT-1:0] step_lvl;
    logic [sps_pkg::AXIS_COUNT-1:0] dir_lvl;
    logic [sps_pkg::AXIS_COUNT-1:0] inv_mask;

    four_axis_step_pulse_generator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_steps_x       (s_steps_x),
        .s_steps_y       (s_steps_y),
        .s_steps_z       (s_steps_z),
        .s_steps_e       (s_steps_e),
        .s_period_x      (s_period_x),
        .s_period_y      (s_period_y),
        .s_period_z      (s_period_z),
        .s_period_e      (s_period_e),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_step_pins     (m_step_pins),
        .m_dir_pins      (m_dir_pins),
        .m_toggled_mask  (m_toggled_mask),
        .m_busy_res      (m_busy_res),
        .m_load_rejected (m_load_rejected)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic move_t mk(input logic [sps_pkg::CMD_WIDTH-1:0] cmd,
                                 input logic [15:0] sx, input logic [15:0] sy,
                                 input logic [15:0] sz, input logic [15:0] se,
                                 input logic [15:0] px, input logic [15:0] py,
                                 input logic [15:0] pz, input logic [15:0] pe);
        move_t m;
        m.cmd    = cmd;
        m.steps  = {se, sz, sy, sx};
        m.period = {pe, pz, py, px};
        return m;
    endfunction

    function automatic move_t cmd_only(input logic [sps_pkg::CMD_WIDTH-1:0] cmd);
        return mk(cmd, NIL, NIL, NIL, NIL, NIL, NIL, NIL, NIL);
    endfunction

    function automatic pins_t predict_pins(input move_t b);
        pins_t                          r;
        logic [16:0]                    mag[sps_pkg::AXIS_COUNT];
        logic [sps_pkg::AXIS_COUNT-1:0] raw;
        bit                             bad;
        int                             a;
        r   = '0;
        raw = '0;
        bad = 0;
        unique case (b.cmd)
            sps_pkg::CMD_TICK: begin
                for (a = 0; a < sps_pkg::AXIS_COUNT; a++) begin
                    tick_cnt[a] = tick_cnt[a] + 16'd1;
                    if (axis_per[a] != 16'd0 && tick_cnt[a] >= axis_per[a]) begin
                        tick_cnt[a] = 16'd0;
                        if (steps_rem[a] != 16'd0) begin
                            steps_rem[a] = steps_rem[a] - 16'd1;
                            step_lvl[a]  = ~step_lvl[a];
                            r.toggled[a] = 1'b1;
                        end
                    end
                end
            end
            sps_pkg::CMD_LOAD: begin
                for (a = 0; a < sps_pkg::AXIS_COUNT; a++) begin
                    mag[a] = b.steps[a][15] ? 17'h10000 - {1'b0, b.steps[a]}
                                            : {1'b0, b.steps[a]};
                    if (b.steps[a][15] || b.steps[a] == 16'd0)
                        raw[a] = 1'b1;
                    if (mag[a] != 17'd0 && b.period[a] == 16'd0)
                        bad = 1;
                end
                if (bad) begin
                    r.rejected = 1'b1;
                end else begin
                    for (a = 0; a < sps_pkg::AXIS_COUNT; a++) begin
                        steps_rem[a] = mag[a][15:0];
                        axis_per[a]  = b.period[a];
                    end
                    dir_lvl = raw ^ inv_mask;
                end
            end
            sps_pkg::CMD_STOP: begin
                for (a = 0; a < sps_pkg::AXIS_COUNT; a++) begin
                    tick_cnt[a] = 16'd0;
                    axis_per[a] = 16'd0;
                end
            end
            default: ;
        endcase
        r.step_pins = step_lvl;
        r.dir_pins  = dir_lvl;
        for (a = 0; a < sps_pkg::AXIS_COUNT; a++)
            if (steps_rem[a] != 16'd0)
                r.busy = 1'b1;
        return r;
    endfunction

    function automatic move_t rand_move();
        move_t m;
        int    sel;
        int    a;
        int    v;
        int    shape;
        m.steps  = {$urandom, $urandom};
        m.period = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            m.cmd = sps_pkg::CMD_TICK;
        end else if (sel < 85) begin
            m.cmd = sps_pkg::CMD_LOAD;
            for (a = 0; a < sps_pkg::AXIS_COUNT; a++) begin
                shape = $urandom_range(0, 9);
                v     = $urandom_range(1, 40);
                if (shape <= 6) begin
                    m.steps[a]  = $urandom_range(0, 1) ? 16'(-v) : 16'(v);
                    m.period[a] = 16'($urandom_range(1, 6));
                end else if (shape == 7) begin
                    m.steps[a] = 16'd0;
                    if ($urandom_range(0, 1))
                        m.period[a] = 16'd0;
                end else if (shape == 8) begin
                    if (m.steps[a] == 16'd0)
                        m.steps[a] = 16'h8000;
                    m.period[a] = 16'($urandom_range(1, 4));
                end else begin
                    m.steps[a] = $urandom_range(0, 1) ? 16'(-v) : 16'(v);
                    if (m.period[a] == 16'd0)
                        m.period[a] = 16'd1;
                end
            end
        end else if (sel < 90) begin
            m.cmd = sps_pkg::CMD_LOAD;
            a = $urandom_range(0, sps_pkg::AXIS_COUNT - 1);
            if (m.steps[a] == 16'd0)
                m.steps[a] = 16'd1;
            m.period[a] = 16'd0;
        end else if (sel < 94) begin
            m.cmd = sps_pkg::CMD_STOP;
        end else if (sel < 97) begin
            m.cmd = CMD_NOP;
        end else begin
            m.cmd = sps_pkg::CMD_LOAD;
        end
        return m;
    endfunction

    task automatic drive_beat(input move_t b, input logic typed, input pins_t want);
        int    gap;
        pins_t p;
        gap = (src_burst > 0) ? 0 : $urandom_range(0, 14);
        if (src_burst > 0)
            src_burst--;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= b.cmd;
        s_steps_x  <= b.steps[0];
        s_steps_y  <= b.steps[1];
        s_steps_z  <= b.steps[2];
        s_steps_e  <= b.steps[3];
        s_period_x <= b.period[0];
        s_period_y <= b.period[1];
        s_period_z <= b.period[2];
        s_period_e <= b.period[3];
        do @(posedge aclk); while (!s_ready);
        p = predict_pins(b);
        pin_results_q.push_back(typed ? want : p);
        beats_sent++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pin_results_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_dir_invert(input logic [sps_pkg::AXIS_COUNT-1:0] mask);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIR_INVERT_ADDR;
        pwdata  <= sps_pkg::APB_DATA_WIDTH'(mask);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        inv_mask = mask;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : sink
        int stall;
        int calm;
        calm    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (calm > 0) begin
                calm--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 14);
                if ($urandom_range(0, 49) == 0)
                    calm = $urandom_range(20, 60);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : scoreboard
        pins_t got;
        pins_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_step_pins, m_dir_pins, m_toggled_mask, m_busy_res, m_load_rejected};
            if (pin_results_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: step %h dir %h tog %h busy %b rej %b",
                             got.step_pins, got.dir_pins, got.toggled, got.busy, got.rejected);
            end else begin
                want = pin_results_q.pop_front();
                if (got.step_pins !== want.step_pins || got.dir_pins !== want.dir_pins ||
                    got.toggled !== want.toggled || got.busy !== want.busy ||
                    got.rejected !== want.rejected) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: want step %h dir %h tog %h busy %b rej %b",
                                 want.step_pins, want.dir_pins, want.toggled, want.busy,
                                 want.rejected);
                        $display("          got  step %h dir %h tog %h busy %b rej %b",
                                 got.step_pins, got.dir_pins, got.toggled, got.busy,
                                 got.rejected);
                    end
                end
                if (got.toggled != '0)
                    toggle_results++;
                if (got.rejected)
                    reject_results++;
            end
        end
    end

    initial begin : stimulus
        row_t                           rows[$];
        logic [sps_pkg::AXIS_COUNT-1:0] masks[5];
        int                             i;
        int                             ph;
        int                             a;
        errors     = 0;
        cycles     = 0;
        beats_sent = 0;
        src_burst  = 0;
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_command  = sps_pkg::CMD_TICK;
        s_steps_x  = '0;
        s_steps_y  = '0;
        s_steps_z  = '0;
        s_steps_e  = '0;
        s_period_x = '0;
        s_period_y = '0;
        s_period_z = '0;
        s_period_e = '0;
        toggle_results = 0;
        reject_results = 0;
        for (a = 0; a < sps_pkg::AXIS_COUNT; a++) begin
            tick_cnt[a]  = 16'd0;
            axis_per[a]  = 16'd0;
            steps_rem[a] = 16'd0;
        end
        step_lvl = '0;
        dir_lvl  = '0;
        inv_mask = '0;

        rows.push_back('{cmd_only(sps_pkg::CMD_TICK), 1'b1,
                         pins_t'{4'h0, 4'h0, 4'h0, 1'b0, 1'b0}});
        rows.push_back('{mk(CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
                         pins_t'{4'h0, 4'h0, 4'h0, 1'b0, 1'b0}});
        rows.push_back('{mk(sps_pkg::CMD_LOAD, 16'd5, NIL, NIL, NIL, NIL, NIL, NIL, NIL), 1'b1,
                         pins_t'{4'h0, 4'h0, 4'h0, 1'b0, 1'b1}});
        rows.push_back('{cmd_only(sps_pkg::CMD_LOAD), 1'b1,
                         pins_t'{4'h0, 4'hF, 4'h0, 1'b0, 1'b0}});
        rows.push_back('{mk(sps_pkg::CMD_LOAD, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                            16'd1, 16'hFFFF, 16'd2, 16'd3), 1'b1,
                         pins_t'{4'h0, 4'h5, 4'h0, 1'b1, 1'b0}});
        repeat (4) rows.push_back('{cmd_only(sps_pkg::CMD_TICK), 1'b0, '0});
        rows.push_back('{mk(sps_pkg::CMD_LOAD, 16'd2, 16'd3, NIL, NIL, 16'd1, NIL, NIL, NIL),
                         1'b0, '0});
        rows.push_back('{cmd_only(sps_pkg::CMD_STOP), 1'b0, '0});
        rows.push_back('{cmd_only(sps_pkg::CMD_TICK), 1'b0, '0});
        rows.push_back('{cmd_only(CMD_NOP), 1'b0, '0});
        rows.push_back('{mk(sps_pkg::CMD_LOAD, 16'd2, 16'hFFFE, 16'd3, 16'hFFFD,
                            16'd1, 16'd1, 16'd1, 16'd1), 1'b0, '0});
        repeat (6) rows.push_back('{cmd_only(sps_pkg::CMD_TICK), 1'b0, '0});
        rows.push_back('{mk(sps_pkg::CMD_LOAD, NIL, NIL, NIL, NIL,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0});
        rows.push_back('{cmd_only(sps_pkg::CMD_TICK), 1'b0, '0});
        rows.push_back('{mk(sps_pkg::CMD_LOAD, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8001,
                            16'hAAAA, 16'h5555, 16'd1, 16'hFFFF), 1'b0, '0});
        rows.push_back('{cmd_only(sps_pkg::CMD_STOP), 1'b0, '0});

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i])
            drive_beat(rows[i].beat, rows[i].typed, rows[i].want);
        settle();

        masks[0] = 4'hF;
        masks[1] = 4'h5;
        masks[2] = 4'hA;
        masks[3] = 4'h0;
        masks[4] = 4'($urandom);
        for (ph = 0; ph < 5; ph++) begin
            write_dir_invert(masks[ph]);
            for (i = 0; i < PHASE_BEATS; i++) begin
                if (i == PHASE_BEATS / 2)
                    settle();
                if (src_burst == 0 && $urandom_range(0, 39) == 0)
                    src_burst = $urandom_range(20, 60);
                drive_beat(rand_move(), 1'b0, '0);
            end
            settle();
        end

        settle();
        repeat (8) @(posedge aclk);
        if (pin_results_q.size() != 0)
            errors++;
        $display("Covered %0d beats over five invert settings with source and sink stalls.",
                 beats_sent);
        $display("Results with toggles: %0d, rejected loads: %0d, mismatches: %0d.",
                 toggle_results, reject_results, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
